>>> rtl/core/line_hash_multiply_fold_defines.svh
// Assertion macros shared by the line hash RTL.
// Depends on nothing; the asserting module must provide clk and arst_n.
`ifndef LINE_HASH_MULTIPLY_FOLD_DEFINES_SVH
`define LINE_HASH_MULTIPLY_FOLD_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LHMF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LHMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lhmf_pkg.sv
// Package for the line hash: constants, port widths and the tail byte mask.
// Depends on nothing; used by lhmf_fold and line_hash_multiply_fold.
package lhmf_pkg;

	localparam int WORD_W      = 64;
	localparam int LEN_W       = 32;
	localparam int TAIL_W      = 4;
	localparam int CHUNK_BYTES = 16;

	// Bits of the line length that take part in the seed.
	localparam int LENGTH_BITS = 32;
	localparam logic [LEN_W-1:0] LEN_MASK = (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} :
		LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [WORD_W-1:0] HASH_P1 = 64'ha076_1d64_78bd_642f;
	localparam logic [WORD_W-1:0] HASH_P2 = 64'he703_7ed1_a0b4_28db;

	// Input tdata: line_length, chunk_low, chunk_high, tail_bytes, padded to bytes.
	localparam int S_FIELDS_W = LEN_W + 2 * WORD_W + TAIL_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = WORD_W;

	// Byte-granular mask that keeps the first tail bytes of a 16-byte chunk.
	function automatic logic [2*WORD_W-1:0] tail_mask(input logic [TAIL_W-1:0] tail);
		logic [2*WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < CHUNK_BYTES; i++) begin
			if (TAIL_W'(i) < tail) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

>>> rtl/core/lhmf_fold.sv
// Multiply-fold: 64x64 product split into halves that are XORed together.
// Depends on lhmf_pkg for the word width.
module lhmf_fold (
	input  logic [lhmf_pkg::WORD_W-1:0] a,
	input  logic [lhmf_pkg::WORD_W-1:0] b,
	output logic [lhmf_pkg::WORD_W-1:0] folded
);
	import lhmf_pkg::*;

	localparam int HALF_W = WORD_W / 2;

	logic [WORD_W-1:0]   p00, p01, p10, p11;
	logic [2*WORD_W-1:0] prod;

	// Four 32x32 partial products, summed into the full 128-bit product.
	assign p00 = WORD_W'(a[HALF_W-1:0])      * WORD_W'(b[HALF_W-1:0]);
	assign p01 = WORD_W'(a[HALF_W-1:0])      * WORD_W'(b[WORD_W-1:HALF_W]);
	assign p10 = WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[HALF_W-1:0]);
	assign p11 = WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[WORD_W-1:HALF_W]);

	assign prod = {{WORD_W{1'b0}}, p00}
		+ {{HALF_W{1'b0}}, p01, {HALF_W{1'b0}}}
		+ {{HALF_W{1'b0}}, p10, {HALF_W{1'b0}}}
		+ {p11, {WORD_W{1'b0}}};

	assign folded = prod[WORD_W-1:0] ^ prod[2*WORD_W-1:WORD_W];

endmodule

>>> rtl/core/line_hash_multiply_fold.sv
// Line hash: an accepted chunk is held in the input register and folded as it leaves it,
// and a tail chunk's hash is loaded into the result register there.
// Throughput is one chunk per cycle while the result register is free; a hash held on
// m_axis stalls the input register. arst_n clears the running hash, open-line flag and valids.
// Depends on lhmf_pkg, lhmf_fold and line_hash_multiply_fold_defines.svh.
`include "line_hash_multiply_fold_defines.svh"

module line_hash_multiply_fold (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input chunks.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// From bit 0: line_length[31:0], chunk_low[63:0], chunk_high[63:0],
	// tail_bytes[3:0], zero padding.
	input  logic [lhmf_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// Bit 0: begin_req.
	input  logic                           s_axis_tuser,
	// last: the tail chunk that completes the line.
	input  logic                           s_axis_tlast,
	// Line hashes.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// From bit 0: line_hash[63:0].
	output logic [lhmf_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import lhmf_pkg::*;

	// Field offsets inside s_axis_tdata.
	localparam int LO_OFS   = LEN_W;
	localparam int HI_OFS   = LEN_W + WORD_W;
	localparam int TAIL_OFS = LEN_W + 2 * WORD_W;

	// Input register: one chunk waiting to be folded.
	logic              valid_s1;
	logic              begin_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [WORD_W-1:0] lo_s1;
	logic [WORD_W-1:0] hi_s1;
	logic [TAIL_W-1:0] tail_s1;
	logic              last_s1;

	// Result register.
	logic              valid_s2;
	logic [WORD_W-1:0] hash_s2;

	// Running state of the open line.
	logic [WORD_W-1:0] running_hash_q;
	logic              in_line_q;

	logic              s_fire;
	logic              out_free;
	logic              s1_fire;
	logic              line_open;
	logic              emit;
	logic [WORD_W-1:0] seed_hash;
	logic [2*WORD_W-1:0] keep_mask;
	logic [WORD_W-1:0] lo_masked;
	logic [WORD_W-1:0] hi_masked;
	logic [WORD_W-1:0] fold_a;
	logic [WORD_W-1:0] fold_b;
	logic [WORD_W-1:0] new_hash;

	// The input register drains whenever the result register can take a new
	// hash, so a waiting result only stalls the chunk behind it.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign s1_fire       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// A begin chunk reseeds from the length, dropping any open line. Chunks
	// that arrive with no line open are ignored.
	assign seed_hash = begin_s1 ? (WORD_W'(len_s1 & LEN_MASK) ^ HASH_P1) : running_hash_q;
	assign line_open = begin_s1 || in_line_q;
	assign emit      = line_open && last_s1;

	// Only the tail chunk is trimmed; a tail of zero clears both words.
	assign keep_mask = tail_mask(tail_s1);
	assign lo_masked = last_s1 ? (lo_s1 & keep_mask[WORD_W-1:0]) : lo_s1;
	assign hi_masked = last_s1 ? (hi_s1 & keep_mask[2*WORD_W-1:WORD_W]) : hi_s1;

	assign fold_a = lo_masked ^ HASH_P1;
	assign fold_b = hi_masked ^ seed_hash ^ HASH_P2;

	lhmf_fold u_fold (
		.a      (fold_a),
		.b      (fold_b),
		.folded (new_hash)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			running_hash_q <= '0;
			in_line_q      <= 1'b0;
		end else begin
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			if (s1_fire && emit) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end

			if (s1_fire && line_open) begin
				running_hash_q <= new_hash;
				in_line_q      <= !last_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			begin_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
			len_s1   <= s_axis_tdata[LEN_W-1:0];
			lo_s1    <= s_axis_tdata[LO_OFS +: WORD_W];
			hi_s1    <= s_axis_tdata[HI_OFS +: WORD_W];
			tail_s1  <= s_axis_tdata[TAIL_OFS +: TAIL_W];
		end
		if (s1_fire && emit) begin
			hash_s2 <= new_hash;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = hash_s2;

	// A completed line always shows up in the result register.
	`LHMF_ASSERT_NEXT(a_emit_result, s1_fire && emit, valid_s2 && (hash_s2 == $past(new_hash)), "line end did not produce its hash")
	// A tail chunk closes the line it completes.
	`LHMF_ASSERT_NEXT(a_tail_closes, s1_fire && last_s1, !in_line_q, "line still open after its tail chunk")
	// A begin chunk that is not the tail opens a line.
	`LHMF_ASSERT_NEXT(a_begin_opens, s1_fire && begin_s1 && !last_s1, in_line_q, "begin chunk did not open a line")
	// Back-pressure only comes from a chunk held in the input register behind a waiting result.
	`LHMF_ASSERT_NOW(a_stall_source, !s_axis_tready, valid_s1 && valid_s2, "input stalled with nothing held")

endmodule
